// File: design/bcle_pkg.sv
// Package for the bounded ordered list engine.
// Holds list depth, derived widths, operation and status codes, and the
// structs passed between the engine, its entry store and the top level.
package bcle_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int CNT_W      = 5;
  localparam int VAL_W      = 8;
  localparam int CMP_W      = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int CNT_MAX    = (1 << CNT_W) - 1;

  typedef enum logic [2:0] {
    KIND_APPEND     = 3'd0,
    KIND_INSERT     = 3'd1,
    KIND_REMOVE_AT  = 3'd2,
    KIND_REMOVE_ALL = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // one write port and one registered read port
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

  // one finished result
  typedef struct packed {
    status_t          status;
    logic             found;
    logic [CNT_W-1:0] match_count;
    logic [CNT_W-1:0] list_length;
  } res_t;

  // clamp a list-sized count to the result field width
  function automatic logic [CNT_W-1:0] sat_count(input logic [LEN_W-1:0] v);
    logic [CMP_W:0] e;
    e = (CMP_W + 1)'(v);
    if (e > (CMP_W + 1)'(CNT_MAX)) begin
      return CNT_W'(CNT_MAX);
    end
    return CNT_W'(v);
  endfunction

endpackage

// File: design/bcle_store.sv
// Entry store of the list engine: one write port, one registered read.
// Depends on bcle_pkg for depth, widths and the request struct.
module bcle_store (
  input  logic                       clk,
  input  bcle_pkg::store_req_t       sreq,
  output logic [bcle_pkg::VAL_W-1:0] rdata
);
  import bcle_pkg::*;

  logic [VAL_W-1:0] mem [LIST_DEPTH];

  // write and registered read; read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (sreq.we) begin
      mem[sreq.waddr] <= sreq.wdata;
    end
    rdata <= mem[sreq.raddr];
  end

endmodule

// File: design/bcle_engine.sv
// Sequencer of the list engine: walks the entry store one entry a cycle
// through one shared step counter and one compare. Depends on bcle_pkg.
module bcle_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 kind,
  input  logic [bcle_pkg::VAL_W-1:0] item_value,
  input  logic [bcle_pkg::POS_W-1:0] position,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bcle_pkg::res_t             res,
  output bcle_pkg::store_req_t       sreq,
  input  logic [bcle_pkg::VAL_W-1:0] rdata
);
  import bcle_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WORK, S_TAIL, S_DONE} state_t;

  state_t           state, state_next;
  kind_t            op, op_next;
  status_t          stat, stat_next;
  logic             found, found_next;
  logic [VAL_W-1:0] val, val_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] pidx, pidx_next;
  logic [LEN_W-1:0] count, count_next;
  logic [LEN_W-1:0] wr_ptr, wr_ptr_next;
  logic [IDX_W-1:0] rd_ptr, rd_ptr_next;
  logic [IDX_W-1:0] addr_q, addr_q_next;
  logic             issuing, issuing_next;
  logic             live, live_next;

  logic [LEN_W-1:0] len_m1;
  logic [CMP_W-1:0] pos_ext, len_ext, sat_pos;
  logic             full;
  logic             hit;
  logic [IDX_W-1:0] last_ptr;

  assign len_m1  = len - LEN_W'(1);
  assign pos_ext = CMP_W'(position);
  assign len_ext = CMP_W'(len);
  assign sat_pos = (pos_ext > len_ext) ? len_ext : pos_ext;
  assign full    = (len == LEN_W'(LIST_DEPTH));
  // shared compare unit
  assign hit     = (rdata == val);
  assign last_ptr = (op == KIND_INSERT) ? pidx[IDX_W-1:0] : len_m1[IDX_W-1:0];

  assign in_ready          = (state == S_IDLE);
  assign res_valid         = (state == S_DONE);
  assign res.status        = stat;
  assign res.found         = found;
  assign res.match_count   = sat_count(count);
  assign res.list_length   = sat_count(len);

  // next-state and store request logic
  always_comb begin
    state_next   = state;
    op_next      = op;
    stat_next    = stat;
    found_next   = found;
    val_next     = val;
    len_next     = len;
    pidx_next    = pidx;
    count_next   = count;
    wr_ptr_next  = wr_ptr;
    rd_ptr_next  = rd_ptr;
    addr_q_next  = addr_q;
    issuing_next = issuing;
    live_next    = live;
    sreq         = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next      = kind_t'(kind);
          val_next     = item_value;
          stat_next    = ST_DONE;
          found_next   = 1'b0;
          count_next   = '0;
          wr_ptr_next  = '0;
          pidx_next    = sat_pos[LEN_W-1:0];
          issuing_next = 1'b1;
          live_next    = 1'b0;
          state_next   = S_DONE;
          case (kind_t'(kind))
            KIND_APPEND, KIND_INSERT: begin
              if (full) begin
                stat_next = ST_FULL;
              end else if ((kind_t'(kind) == KIND_APPEND) || (sat_pos == len_ext)) begin
                // lands at the tail: one write
                sreq.we    = 1'b1;
                sreq.waddr = len[IDX_W-1:0];
                sreq.wdata = item_value;
                len_next   = len + LEN_W'(1);
                op_next    = KIND_APPEND;
              end else begin
                // shift up from the tail down to the insert point
                op_next     = KIND_INSERT;
                rd_ptr_next = len_m1[IDX_W-1:0];
                state_next  = S_WORK;
              end
            end
            KIND_REMOVE_AT: begin
              if (pos_ext >= len_ext) begin
                stat_next = ST_NONE;
              end else if (pos_ext == CMP_W'(len_m1)) begin
                len_next = len_m1;
              end else begin
                rd_ptr_next = position[IDX_W-1:0] + IDX_W'(1);
                state_next  = S_WORK;
              end
            end
            KIND_REMOVE_ALL, KIND_QUERY: begin
              if (len == '0) begin
                if (kind_t'(kind) == KIND_REMOVE_ALL) begin
                  stat_next = ST_NONE;
                end
              end else begin
                rd_ptr_next = '0;
                state_next  = S_WORK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WORK: begin
        // issue one read per cycle
        if (issuing) begin
          sreq.raddr  = rd_ptr;
          live_next   = 1'b1;
          addr_q_next = rd_ptr;
          if (rd_ptr == last_ptr) begin
            issuing_next = 1'b0;
          end else if (op == KIND_INSERT) begin
            rd_ptr_next = rd_ptr - IDX_W'(1);
          end else begin
            rd_ptr_next = rd_ptr + IDX_W'(1);
          end
        end else begin
          live_next = 1'b0;
        end
        // act on the entry read last cycle
        if (live) begin
          case (op)
            KIND_INSERT: begin
              sreq.we    = 1'b1;
              sreq.waddr = addr_q + IDX_W'(1);
              sreq.wdata = rdata;
            end
            KIND_REMOVE_AT: begin
              sreq.we    = 1'b1;
              sreq.waddr = addr_q - IDX_W'(1);
              sreq.wdata = rdata;
            end
            KIND_REMOVE_ALL: begin
              if (hit) begin
                count_next = count + LEN_W'(1);
              end else begin
                sreq.we     = 1'b1;
                sreq.waddr  = wr_ptr[IDX_W-1:0];
                sreq.wdata  = rdata;
                wr_ptr_next = wr_ptr + LEN_W'(1);
              end
            end
            KIND_QUERY: begin
              if (hit) begin
                count_next = count + LEN_W'(1);
              end
            end
            default: begin
            end
          endcase
          if (!issuing) begin
            state_next = S_TAIL;
          end
        end
      end

      S_TAIL: begin
        state_next = S_DONE;
        live_next  = 1'b0;
        case (op)
          KIND_INSERT: begin
            sreq.we    = 1'b1;
            sreq.waddr = pidx[IDX_W-1:0];
            sreq.wdata = val;
            len_next   = len + LEN_W'(1);
          end
          KIND_REMOVE_AT: begin
            len_next = len_m1;
          end
          KIND_REMOVE_ALL: begin
            len_next = wr_ptr;
            if (count == '0) begin
              stat_next = ST_NONE;
            end
          end
          KIND_QUERY: begin
            found_next = (count != '0);
          end
          default: begin
          end
        endcase
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len     <= '0;
      issuing <= 1'b0;
      live    <= 1'b0;
    end else begin
      state   <= state_next;
      len     <= len_next;
      issuing <= issuing_next;
      live    <= live_next;
    end
    op     <= op_next;
    stat   <= stat_next;
    found  <= found_next;
    val    <= val_next;
    pidx   <= pidx_next;
    count  <= count_next;
    wr_ptr <= wr_ptr_next;
    rd_ptr <= rd_ptr_next;
    addr_q <= addr_q_next;
  end

  // length stays within the store
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(LIST_DEPTH))
    else $error("list length past depth");

  // writes stay inside the store
  a_waddr_bound: assert property (@(posedge clk) disable iff (rst)
    sreq.we |-> ((LEN_W + 1)'(sreq.waddr) < (LEN_W + 1)'(LIST_DEPTH)))
    else $error("store write out of range");

  // an accepted request closes the input until its result is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // remove-all never counts more entries than it has walked
  a_compact_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORK && op == KIND_REMOVE_ALL)
      |-> ((LEN_W + 1)'(count) + (LEN_W + 1)'(wr_ptr) <= (LEN_W + 1)'(len)))
    else $error("remove-all counts overrun length");

endmodule

// File: design/bounded_char_list_engine_core.sv
// Top level of the bounded ordered list engine.
// Instantiates bcle_engine and bcle_store; uses bcle_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: kind, item_value
//   and position. Output channel (out_valid/out_ready) returns one result
//   per request: status, found, match_count and list_length.
//   in_ready is high only while the sequencer is idle; one request is in
//   work at a time.
// Result path:
//   Append, full-list inserts, tail removes, out-of-range removes, unused
//   kinds and operations on an empty list go from idle straight to the done
//   state, then into the output register that raises out_valid. Shifting
//   inserts and removes and the remove-all and query walks read one entry a
//   cycle from the single-read-port entry store before the done state. A
//   new request is taken in the cycle after the result moves to the output
//   register.
// Reset:
//   rst (synchronous) empties the list and clears both channels; the
//   entries themselves are not cleared.
// Stall:
//   A result waits in the output register while out_ready is low; the next
//   request may be accepted and worked, and its result is held in the
//   sequencer until the output register frees up.
module bounded_char_list_engine_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 kind,
  input  logic [bcle_pkg::VAL_W-1:0] item_value,
  input  logic [bcle_pkg::POS_W-1:0] position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       found,
  output logic [bcle_pkg::CNT_W-1:0] match_count,
  output logic [bcle_pkg::CNT_W-1:0] list_length
);
  import bcle_pkg::*;

  store_req_t       sreq;
  logic [VAL_W-1:0] rdata;
  res_t             res;
  logic             res_valid;
  logic             res_ready;

  bcle_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .item_value (item_value),
    .position   (position),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .sreq       (sreq),
    .rdata      (rdata)
  );

  bcle_store u_store (
    .clk   (clk),
    .sreq  (sreq),
    .rdata (rdata)
  );

  // output register parts the sequencer from the receiver
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      status      <= res.status;
      found       <= res.found;
      match_count <= res.match_count;
      list_length <= res.list_length;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the bounded ordered list engine core.
// Depends on bcle_pkg for widths, operation and status codes and the result struct.
module testbench;
  import bcle_pkg::*;

  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          RANDOM_ITEMS  = 450;
  localparam int          CHOKE_AFTER   = 120;
  localparam int          CHOKE_CYCLES  = 400;
  localparam int          DRAIN_CYCLES  = 40;
  localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;

  // expected-result tracking: mirror of the list plus the queue of pending results
  class list_scoreboard;
    logic [VAL_W-1:0] items[$];
    res_t             expected_q[$];
    int               errors = 0;
    int               accepted = 0;

    function int size();
      return items.size();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [CNT_W-1:0] clamp_count(int v);
      return (v > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(v);
    endfunction

    // apply one accepted request to the mirror and queue its result
    function void note_request(logic [2:0] op, logic [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      res_t             r;
      int               hits;
      int               at;
      logic [VAL_W-1:0] kept[$];
      r = '0;
      r.status = ST_DONE;
      hits = 0;
      accepted++;
      case (op)
        KIND_APPEND, KIND_INSERT: begin
          if (items.size() >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            at = (op == KIND_APPEND) ? items.size() : int'(pos);
            if (at > items.size()) at = items.size();
            items.insert(at, val);
          end
        end
        KIND_REMOVE_AT: begin
          if (int'(pos) < items.size()) items.delete(int'(pos));
          else r.status = ST_NONE;
        end
        KIND_REMOVE_ALL: begin
          foreach (items[i]) begin
            if (items[i] == val) hits++;
            else kept.push_back(items[i]);
          end
          items = kept;
          if (hits == 0) r.status = ST_NONE;
          r.match_count = clamp_count(hits);
        end
        KIND_QUERY: begin
          foreach (items[i]) if (items[i] == val) hits++;
          r.found = (hits != 0);
          r.match_count = clamp_count(hits);
        end
        default: ;  // spare kinds leave the list alone
      endcase
      r.list_length = clamp_count(items.size());
      expected_q.push_back(r);
    endfunction

    function void report(string field, int exp_v, int act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endfunction

    // compare one accepted result with the oldest pending expectation
    function void check_result(logic [1:0] st, logic fnd, logic [CNT_W-1:0] mc,
                               logic [CNT_W-1:0] ll);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, actual %0d/%0d/%0d/%0d",
                 $time, st, fnd, mc, ll);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status) report("status", e.status, st);
      if (fnd !== e.found) report("found", e.found, fnd);
      if (mc !== e.match_count) report("match_count", e.match_count, mc);
      if (ll !== e.list_length) report("list_length", e.list_length, ll);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        kind;
  logic [VAL_W-1:0]  item_value;
  logic [POS_W-1:0]  position;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic              found;
  logic [CNT_W-1:0]  match_count;
  logic [CNT_W-1:0]  list_length;

  list_scoreboard    sb = new;
  int                cycles = 0;
  bit                choke_done = 1'b0;

  bounded_char_list_engine_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .item_value  (item_value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .match_count (match_count),
    .list_length (list_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // request and result monitors
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(kind, item_value, position);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, found, match_count, list_length);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(logic [2:0] k, logic [VAL_W-1:0] v, logic [POS_W-1:0] p,
                              int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    item_value <= v;
    position   <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // result side: random stalls, calm windows, and one long hold-off
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!choke_done && sb.accepted >= CHOKE_AFTER) begin
        choke_done = 1'b1;
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else if (((cycles / 400) % 4) == 1) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // request side: reset, directed cases, then biased random traffic
  initial begin : sender
    logic [VAL_W-1:0] pool[6];
    logic [2:0]       k;
    logic [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    int               r;
    int               len;
    bit               filling;
    pool = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= KIND_APPEND;
    item_value <= '0;
    position   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list
    send_request(KIND_QUERY,      8'h00, 5'd0,  pick_gap());
    send_request(KIND_REMOVE_AT,  8'h00, 5'd0,  pick_gap());
    send_request(KIND_REMOVE_ALL, 8'hFF, 5'd0,  pick_gap());
    // inserts, including an index past the end
    send_request(KIND_APPEND,     8'hFF, 5'd0,  pick_gap());
    send_request(KIND_INSERT,     8'h00, 5'd16, pick_gap());
    send_request(KIND_INSERT,     8'h55, 5'd0,  pick_gap());
    send_request(KIND_INSERT,     8'h55, 5'd1,  pick_gap());
    send_request(KIND_QUERY,      8'h55, 5'd0,  pick_gap());
    send_request(KIND_QUERY,      8'h01, 5'd0,  pick_gap());
    // removes: out of range, tail, head, all-equal
    send_request(KIND_REMOVE_AT,  8'h00, 5'd16, pick_gap());
    send_request(KIND_REMOVE_AT,  8'h00, 5'd3,  pick_gap());
    send_request(KIND_REMOVE_AT,  8'h00, 5'd0,  pick_gap());
    send_request(KIND_REMOVE_ALL, 8'h55, 5'd0,  pick_gap());
    send_request(KIND_SPARE_LO,   8'hAA, 5'd1,  pick_gap());
    send_request(KIND_SPARE_HI,   8'h55, 5'd31, pick_gap());

    // alternate fill and drain phases so the list swings between empty and full
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      filling = ((n / 40) % 2) == 0;
      len = sb.size();
      r = $urandom_range(0, 99);
      if (r < 2) k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (filling)
        k = (r < 45) ? KIND_APPEND : (r < 75) ? KIND_INSERT : (r < 83) ? KIND_REMOVE_AT :
            (r < 90) ? KIND_REMOVE_ALL : KIND_QUERY;
      else
        k = (r < 15) ? KIND_APPEND : (r < 25) ? KIND_INSERT : (r < 55) ? KIND_REMOVE_AT :
            (r < 75) ? KIND_REMOVE_ALL : KIND_QUERY;
      if ($urandom_range(0, 3) != 0) v = pool[$urandom_range(0, 5)];
      else v = VAL_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) p = POS_W'($urandom_range(0, 16));
      else p = POS_W'($urandom_range(0, len));
      send_request(k, v, p, (((n / 60) % 4) == 2) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
